// ===== rtl/detg_pkg.sv =====
// Shared types, codes and reset values of the debounced edge trigger gate.
package detg_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned NumChannelsDefault = 4;
  localparam int unsigned TimeWidthDefault   = 32;

  // Fixed field widths.
  localparam int unsigned ChanW    = 2;
  localparam int unsigned StampW   = 32;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned ModesW   = 8;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  typedef logic [StatusW-1:0] status_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Result status codes.
  localparam status_t StNone      = 4'd0;
  localparam status_t StFirst     = 4'd1;
  localparam status_t StNoTrig    = 4'd2;
  localparam status_t StRequest   = 4'd3;
  localparam status_t StLatched   = 4'd4;
  localparam status_t StInFlight  = 4'd5;
  localparam status_t StCooldown  = 4'd6;
  localparam status_t StNotReady  = 4'd7;
  localparam status_t StAccepted  = 4'd8;
  localparam status_t StRejected  = 4'd9;

  // Configuration register indexes.
  localparam cfg_idx_t CfgActiveLowMask  = 3'd0;
  localparam cfg_idx_t CfgTriggerModes   = 3'd1;
  localparam cfg_idx_t CfgDebounceTicks  = 3'd2;
  localparam cfg_idx_t CfgCooldownTicks  = 3'd3;
  localparam cfg_idx_t CfgOnceAfterSucc  = 3'd4;

  // Trigger mode codes; the fourth code behaves as a press.
  localparam logic [1:0] ModePress   = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeBoth    = 2'd2;

  // Item kinds carried in tuser.
  localparam logic ActSample   = 1'b0;
  localparam logic ActResponse = 1'b1;

  // Register reset values.
  localparam logic [MaskW-1:0]    ActiveLowMaskRst = 4'hF;
  localparam logic [ModesW-1:0]   TriggerModesRst  = 8'h00;
  localparam logic [StampW-1:0]   DebounceRst      = 32'd30;
  localparam logic [StampW-1:0]   CooldownRst      = 32'd1000;
  localparam logic                OnceRst          = 1'b1;

endpackage

// ===== rtl/debounced_edge_trigger_gate_top.sv =====
// Top level of the debounced edge trigger gate: debounce store, edge gate and stream ports.
//
//  Port group  Dir  Transfer fields
//  s_axis      in   tuser: action; tdata: channel, raw_pin, now_ticks, service_ready,
//                   response_success
//  m_axis      out  tdata: status, result_channel, debounced_level, start_request
//  cfg         in   write enable, register index, write data
//
// Each item passes through the input register and then the result register;
// a new transfer is taken every cycle while results are drained.
// The per-channel store is read combinationally between the two registers and updated as the result register loads.
// A stall on m_axis holds the result register and, once the input register is full, s_axis.
// Reset clears both registers' valid flags, the store's valid and level flags and the request flags.
module debounced_edge_trigger_gate_top #(
  parameter int unsigned NUM_CHANNELS = detg_pkg::NumChannelsDefault,
  parameter int unsigned TIME_WIDTH   = detg_pkg::TimeWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Bits up from 0: channel[1:0], raw_pin, now_ticks[31:0], service_ready,
  // response_success, zero fill.
  input  logic [detg_pkg::InDataW-1:0]   s_axis_tdata,
  // Bit 0: action.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Bits up from 0: status[3:0], result_channel[1:0], debounced_level, start_request.
  output logic [detg_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [detg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [detg_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CmpW = (TIME_WIDTH > detg_pkg::StampW) ? TIME_WIDTH
                                                                  : detg_pkg::StampW;
  localparam int unsigned ChkW = 5;

  // Configuration registers.
  logic [detg_pkg::MaskW-1:0]  active_low_mask_q;
  logic [detg_pkg::ModesW-1:0] trigger_modes_q;
  logic [detg_pkg::StampW-1:0] debounce_ticks_q;
  logic [detg_pkg::StampW-1:0] cooldown_ticks_q;
  logic                        once_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_mask_q <= detg_pkg::ActiveLowMaskRst;
      trigger_modes_q   <= detg_pkg::TriggerModesRst;
      debounce_ticks_q  <= detg_pkg::DebounceRst;
      cooldown_ticks_q  <= detg_pkg::CooldownRst;
      once_q            <= detg_pkg::OnceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        detg_pkg::CfgActiveLowMask: active_low_mask_q <= cfg_data_i[detg_pkg::MaskW-1:0];
        detg_pkg::CfgTriggerModes:  trigger_modes_q   <= cfg_data_i[detg_pkg::ModesW-1:0];
        detg_pkg::CfgDebounceTicks: debounce_ticks_q  <= cfg_data_i;
        detg_pkg::CfgCooldownTicks: cooldown_ticks_q  <= cfg_data_i;
        detg_pkg::CfgOnceAfterSucc: once_q            <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register and result register.
  logic                         in_valid_q;
  logic                         in_act_q;
  logic [detg_pkg::InDataW-1:0] in_data_q;
  logic                         out_valid_q;
  logic [detg_pkg::OutDataW-1:0] out_data_q;
  logic                         adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Field unpacking.
  logic [detg_pkg::ChanW-1:0]  f_chan;
  logic                        f_raw;
  logic [detg_pkg::StampW-1:0] f_now;
  logic                        f_ready;
  logic                        f_success;
  logic [TIME_WIDTH-1:0]       now_t;

  assign f_chan    = in_data_q[1:0];
  assign f_raw     = in_data_q[2];
  assign f_now     = in_data_q[34:3];
  assign f_ready   = in_data_q[35];
  assign f_success = in_data_q[36];
  assign now_t     = TIME_WIDTH'(f_now);

  // Per-channel debounce store.
  logic                  pend_valid_q  [NUM_CHANNELS];
  logic                  pend_level_q  [NUM_CHANNELS];
  logic [TIME_WIDTH-1:0] pend_start_q  [NUM_CHANNELS];
  logic                  stab_valid_q  [NUM_CHANNELS];
  logic                  stab_level_q  [NUM_CHANNELS];

  // Request state.
  logic                  in_flight_q, in_flight_d;
  logic                  latch_q, latch_d;
  logic                  req_before_q, req_before_d;
  logic [TIME_WIDTH-1:0] last_req_q;

  function automatic logic edge_match(input logic [1:0] mode, input logic prev_lvl,
                                      input logic next_lvl);
    logic hit;
    case (mode)
      detg_pkg::ModeBoth:    hit = prev_lvl != next_lvl;
      detg_pkg::ModeRelease: hit = prev_lvl && !next_lvl;
      default:               hit = !prev_lvl && next_lvl;
    endcase
    return hit;
  endfunction

  logic [IdxW-1:0]       idx;
  logic                  is_sample;
  logic                  ch_ok;
  logic                  active;
  logic                  pv, pl, sv, sl;
  logic [TIME_WIDTH-1:0] ps;
  logic                  new_pend;
  logic                  elapsed;
  logic                  settle;
  logic                  change;
  logic [1:0]            mode;
  logic                  cooling;
  logic                  issue;
  logic                  sv_d, sl_d;
  detg_pkg::status_t     status;
  logic                  level;

  always_comb begin
    idx       = IdxW'(f_chan);
    is_sample = in_act_q == detg_pkg::ActSample;
    ch_ok     = ChkW'(f_chan) < ChkW'(NUM_CHANNELS);
    active    = f_raw ^ active_low_mask_q[f_chan];
    pv        = ch_ok && pend_valid_q[idx];
    pl        = ch_ok && pend_level_q[idx];
    ps        = pend_start_q[idx];
    sv        = ch_ok && stab_valid_q[idx];
    sl        = ch_ok && stab_level_q[idx];
    new_pend  = !pv || (pl != active);
    elapsed   = CmpW'(TIME_WIDTH'(now_t - ps)) >= CmpW'(debounce_ticks_q);
    settle    = ch_ok && !new_pend && elapsed && !sv;
    change    = ch_ok && !new_pend && elapsed && sv && (sl != active);
    mode      = trigger_modes_q[2*f_chan +: 2];
    cooling   = req_before_q &&
                (CmpW'(TIME_WIDTH'(now_t - last_req_q)) < CmpW'(cooldown_ticks_q));
    sv_d      = sv || settle;
    sl_d      = (settle || change) ? active : sl;

    status       = detg_pkg::StNone;
    issue        = 1'b0;
    in_flight_d  = in_flight_q;
    latch_d      = latch_q;
    req_before_d = req_before_q;

    if (!is_sample) begin
      if (in_flight_q) begin
        in_flight_d = 1'b0;
        if (f_success) begin
          if (once_q) begin
            latch_d = 1'b1;
          end
          status = detg_pkg::StAccepted;
        end else begin
          status = detg_pkg::StRejected;
        end
      end
    end else if (settle) begin
      status = detg_pkg::StFirst;
    end else if (change) begin
      if (!edge_match(mode, sl, active)) begin
        status = detg_pkg::StNoTrig;
      end else if (once_q && latch_q) begin
        status = detg_pkg::StLatched;
      end else if (in_flight_q) begin
        status = detg_pkg::StInFlight;
      end else if (cooling) begin
        status = detg_pkg::StCooldown;
      end else if (!f_ready) begin
        status = detg_pkg::StNotReady;
      end else begin
        status       = detg_pkg::StRequest;
        issue        = 1'b1;
        in_flight_d  = 1'b1;
        req_before_d = 1'b1;
      end
    end

    level = is_sample && ch_ok && sv_d && sl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pend_valid_q[i] <= 1'b0;
        pend_level_q[i] <= 1'b0;
        stab_valid_q[i] <= 1'b0;
        stab_level_q[i] <= 1'b0;
      end
      in_flight_q  <= 1'b0;
      latch_q      <= 1'b0;
      req_before_q <= 1'b0;
    end else if (adv) begin
      if (is_sample && ch_ok) begin
        pend_valid_q[idx] <= 1'b1;
        pend_level_q[idx] <= active;
        stab_valid_q[idx] <= sv_d;
        stab_level_q[idx] <= sl_d;
      end
      in_flight_q  <= in_flight_d;
      latch_q      <= latch_d;
      req_before_q <= req_before_d;
    end
  end

  // Time stamps are guarded by their valid flags and need no reset.
  always_ff @(posedge clk_i) begin
    if (adv && is_sample && ch_ok && new_pend) begin
      pend_start_q[idx] <= now_t;
    end
    if (adv && issue) begin
      last_req_q <= now_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {issue, level, is_sample ? f_chan : detg_pkg::ChanW'(0), status};
    end
  end

endmodule

// ===== rtl/detg_checker.sv =====
// Port-level checks of the debounced edge trigger gate and their binding to the top level.
module detg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [detg_pkg::OutDataW-1:0]  m_axis_tdata
);

  detg_pkg::status_t st;
  assign st = m_axis_tdata[3:0];

  // A start request is flagged exactly when the status reports an issued request.
  a_req_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7] == (st == detg_pkg::StRequest)))
    else $error("start_request disagrees with status");

  // Response outcomes carry no channel and no level.
  a_response_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (st == detg_pkg::StAccepted || st == detg_pkg::StRejected))
      |-> (m_axis_tdata[6:4] == 3'd0))
    else $error("response result carries channel or level");

  // Only defined status codes appear.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st <= detg_pkg::StRejected))
    else $error("undefined status code");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind debounced_edge_trigger_gate_top detg_checker u_detg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_debounced_edge_trigger_gate_top.sv =====
// Self-checking testbench for the debounced edge trigger gate with directed and random stimulus.
module tb_debounced_edge_trigger_gate_top;
  timeunit 1ns;
  timeprecision 1ps;

  import detg_pkg::*;

  localparam int NumCh      = NumChannelsDefault;
  localparam int CycleLimit = 300000;

  typedef struct packed {
    logic        action;
    logic [1:0]  chan;
    logic        raw;
    logic [31:0] now;
    logic        ready;
    logic        success;
  } gate_item_t;

  // Packed so that status sits in the lowest bits, as on m_axis_tdata.
  typedef struct packed {
    logic       start;
    logic       level;
    logic [1:0] chan;
    status_t    status;
  } gate_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // Bits up from 0: channel[1:0], raw_pin, now_ticks[31:0], service_ready,
  // response_success, zero fill.
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  // Bit 0: action.
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  // Bits up from 0: status[3:0], result_channel[1:0], debounced_level, start_request.
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  // Shadow copy of the registers.
  logic [MaskW-1:0]  cfg_mask     = ActiveLowMaskRst;
  logic [ModesW-1:0] cfg_modes    = TriggerModesRst;
  logic [31:0]       cfg_debounce = DebounceRst;
  logic [31:0]       cfg_cooldown = CooldownRst;
  logic              cfg_once     = OnceRst;

  // Predicted channel store and request state.
  bit          pend_valid [NumCh];
  bit          pend_level [NumCh];
  bit [31:0]   pend_start [NumCh];
  bit          stab_valid [NumCh];
  bit          stab_level [NumCh];
  bit          gate_in_flight;
  bit          gate_latch;
  bit [31:0]   last_req_ticks;
  bit          req_before;

  gate_result_t expected_results [$];

  int          mismatch_count;
  int          items_sent;
  int          results_checked;
  int          requests_seen;
  int          cfg_writes;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_stall_left;
  bit [NumCh-1:0] held_raw;
  logic [31:0] tick_now;

  debounced_edge_trigger_gate_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run stopped at the cycle limit, %0d results outstanding",
               $time, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Works out the result of one item and advances the predicted state.
  function automatic gate_result_t predict_gate(input gate_item_t it);
    gate_result_t r;
    logic         active;
    logic         prior;
    logic         hit;
    logic [1:0]   mode;
    logic [31:0]  held;
    logic [31:0]  since_req;
    r = '0;
    if (it.action == ActResponse) begin
      if (gate_in_flight) begin
        gate_in_flight = 1'b0;
        if (it.success) begin
          if (cfg_once) gate_latch = 1'b1;
          r.status = StAccepted;
        end else begin
          r.status = StRejected;
        end
      end
    end else begin
      r.chan = it.chan;
      if (it.chan < NumCh) begin
        active = it.raw ^ cfg_mask[it.chan];
        held   = it.now - pend_start[it.chan];
        if (!pend_valid[it.chan] || pend_level[it.chan] != active) begin
          pend_valid[it.chan] = 1'b1;
          pend_level[it.chan] = active;
          pend_start[it.chan] = it.now;
        end else if (held >= cfg_debounce) begin
          if (!stab_valid[it.chan]) begin
            stab_valid[it.chan] = 1'b1;
            stab_level[it.chan] = active;
            r.status = StFirst;
          end else if (stab_level[it.chan] != active) begin
            prior = stab_level[it.chan];
            mode  = cfg_modes[2*it.chan +: 2];
            stab_level[it.chan] = active;
            case (mode)
              ModeBoth:    hit = prior != active;
              ModeRelease: hit = prior && !active;
              default:     hit = !prior && active;
            endcase
            since_req = it.now - last_req_ticks;
            if (!hit) begin
              r.status = StNoTrig;
            end else if (cfg_once && gate_latch) begin
              r.status = StLatched;
            end else if (gate_in_flight) begin
              r.status = StInFlight;
            end else if (req_before && since_req < cfg_cooldown) begin
              r.status = StCooldown;
            end else if (!it.ready) begin
              r.status = StNotReady;
            end else begin
              gate_in_flight = 1'b1;
              req_before     = 1'b1;
              last_req_ticks = it.now;
              r.status       = StRequest;
            end
          end
        end
        r.level = stab_valid[it.chan] && stab_level[it.chan];
      end
    end
    r.start = (r.status == StRequest);
    return r;
  endfunction

  always @(posedge clk_i) begin
    gate_result_t got;
    gate_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.start === 1'b1) requests_seen++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.chan !== want.chan) begin
          $display("%0t: result_channel expected %0d, got %0d", $time, want.chan, got.chan);
          mismatch_count++;
        end
        if (got.level !== want.level) begin
          $display("%0t: debounced_level expected %0b, got %0b", $time, want.level,
                   got.level);
          mismatch_count++;
        end
        if (got.start !== want.start) begin
          $display("%0t: start_request expected %0b, got %0b", $time, want.start,
                   got.start);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one item until its transfer completes, then idles at random.
  task automatic send_item(input gate_item_t it);
    gate_result_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {3'b000, it.success, it.ready, it.now, it.raw, it.chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_gate(it);
    expected_results = {expected_results, pred};
    items_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(input logic [1:0] ch, input logic raw, input logic [31:0] now,
                             input logic ready);
    gate_item_t it;
    it        = '0;
    it.action = ActSample;
    it.chan   = ch;
    it.raw    = raw;
    it.now    = now;
    it.ready  = ready;
    send_item(it);
  endtask

  task automatic send_response(input logic success);
    gate_item_t it;
    it         = '0;
    it.action  = ActResponse;
    it.success = success;
    send_item(it);
  endtask

  // Registers change only once the block has drained every result.
  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgActiveLowMask: cfg_mask     = value[MaskW-1:0];
      CfgTriggerModes:  cfg_modes    = value[ModesW-1:0];
      CfgDebounceTicks: cfg_debounce = value;
      CfgCooldownTicks: cfg_cooldown = value;
      CfgOnceAfterSucc: cfg_once     = value[0];
      default: ;
    endcase
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly held levels with time steps around the debounce window, so that levels
  // settle and edges reach the gate; some glitches, wild time stamps and responses.
  task automatic send_random_items(input int count);
    gate_item_t  it;
    int          pick;
    logic [31:0] step;
    logic [31:0] lim;
    for (int n = 0; n < count; n++) begin
      it   = '0;
      pick = $urandom_range(0, 99);
      if (pick < (gate_in_flight ? 35 : 4)) begin
        it.action  = ActResponse;
        it.chan    = 2'($urandom_range(0, 3));
        it.raw     = 1'($urandom_range(0, 1));
        it.now     = $urandom();
        it.ready   = 1'($urandom_range(0, 1));
        it.success = 1'($urandom_range(0, 1));
      end else begin
        it.action = ActSample;
        it.chan   = 2'($urandom_range(0, NumCh - 1));
        pick      = $urandom_range(0, 99);
        if (pick < 15) held_raw[it.chan] = ~held_raw[it.chan];
        it.raw = held_raw[it.chan];
        if (pick >= 94) it.raw = ~it.raw;
        lim  = (cfg_debounce > 200) ? 32'd200 : cfg_debounce;
        pick = $urandom_range(0, 99);
        if (pick < 45) step = $urandom_range(0, lim);
        else if (pick < 80) step = cfg_debounce + $urandom_range(0, 3);
        else if (pick < 90) step = cfg_debounce - 1;
        else step = $urandom();
        tick_now    = tick_now + step;
        it.now      = tick_now;
        it.ready    = ($urandom_range(0, 9) != 0);
        it.success  = 1'($urandom_range(0, 1));
      end
      send_item(it);
    end
  endtask

  // Walks the reset settings through first settling, every block reason and both
  // response outcomes, ending with the success latch set.
  task automatic test_directed_sequence();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_response(1'b1);
    send_sample(2'd0, 1'b1, 32'd0, 1'b1);
    send_sample(2'd0, 1'b1, 32'd29, 1'b1);
    send_sample(2'd0, 1'b1, 32'd30, 1'b1);
    send_sample(2'd0, 1'b0, 32'd40, 1'b0);
    send_sample(2'd0, 1'b0, 32'd70, 1'b0);
    send_sample(2'd0, 1'b1, 32'd80, 1'b1);
    send_sample(2'd0, 1'b1, 32'd110, 1'b1);
    send_sample(2'd0, 1'b0, 32'd120, 1'b1);
    send_sample(2'd0, 1'b0, 32'd150, 1'b1);
    send_sample(2'd1, 1'b1, 32'd160, 1'b1);
    send_sample(2'd1, 1'b1, 32'd190, 1'b1);
    send_sample(2'd1, 1'b0, 32'd200, 1'b1);
    send_sample(2'd1, 1'b0, 32'd230, 1'b1);
    send_response(1'b0);
    send_sample(2'd1, 1'b1, 32'd240, 1'b1);
    send_sample(2'd1, 1'b1, 32'd270, 1'b1);
    send_sample(2'd1, 1'b0, 32'd280, 1'b1);
    send_sample(2'd1, 1'b0, 32'd310, 1'b1);
    send_sample(2'd1, 1'b1, 32'd320, 1'b1);
    send_sample(2'd1, 1'b1, 32'd350, 1'b1);
    send_sample(2'd1, 1'b0, 32'd1200, 1'b1);
    send_sample(2'd1, 1'b0, 32'd1230, 1'b1);
    send_response(1'b1);
    send_sample(2'd2, 1'b1, 32'd1300, 1'b1);
    send_sample(2'd2, 1'b1, 32'd1330, 1'b1);
    send_sample(2'd2, 1'b0, 32'd1340, 1'b1);
    send_sample(2'd2, 1'b0, 32'd1370, 1'b1);
    tick_now = 32'd1400;
  endtask

  // The latch stays set from here on, so requests need once_after_success cleared.
  task automatic test_polarity_and_modes();
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    write_register(CfgOnceAfterSucc, 32'd0);
    write_register(CfgCooldownTicks, 32'd100);
    write_register(CfgActiveLowMask, 32'h0);
    write_register(CfgTriggerModes, 32'h00);
    send_random_items(100);
    write_register(CfgActiveLowMask, 32'hF);
    write_register(CfgTriggerModes, 32'hFF);
    send_random_items(100);
    write_register(CfgActiveLowMask, 32'h5);
    write_register(CfgTriggerModes, 32'hAA);
    send_random_items(100);
    write_register(CfgActiveLowMask, 32'hA);
    write_register(CfgTriggerModes, 32'h55);
    send_random_items(100);
    write_register(CfgActiveLowMask, $urandom_range(0, 15));
    write_register(CfgTriggerModes, $urandom_range(0, 255));
    send_random_items(100);
  endtask

  task automatic test_debounce_extremes();
    logic lvl;
    tx_idle_pct = 60;
    rx_idle_pct = 60;
    write_register(CfgTriggerModes, 32'hAA);
    write_register(CfgDebounceTicks, 32'd0);
    send_random_items(120);
    // The full window is met only by a stamp one tick behind the pending start.
    write_register(CfgDebounceTicks, 32'hFFFF_FFFF);
    for (int c = 0; c < NumCh; c++) begin
      for (int f = 0; f < 2; f++) begin
        lvl      = held_raw[c] ^ f[0];
        tick_now = tick_now + 32'd7;
        send_sample(c[1:0], ~lvl, tick_now, 1'b1);
        send_sample(c[1:0], lvl, tick_now + 32'd1, 1'b1);
        send_sample(c[1:0], lvl, tick_now, 1'b1);
        send_response(1'($urandom_range(0, 1)));
      end
      held_raw[c] = lvl;
    end
    send_random_items(40);
    write_register(CfgDebounceTicks, $urandom_range(1, 200));
    send_random_items(100);
  endtask

  task automatic test_cooldown_extremes();
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    write_register(CfgDebounceTicks, 32'd30);
    write_register(CfgCooldownTicks, 32'd0);
    send_random_items(100);
    tx_idle_pct = 30;
    rx_idle_pct = 0;
    write_register(CfgCooldownTicks, 32'hFFFF_FFFF);
    send_random_items(100);
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    write_register(CfgCooldownTicks, $urandom_range(1, 3000));
    send_random_items(100);
  endtask

  task automatic test_latch_blocking();
    write_register(CfgCooldownTicks, 32'd0);
    write_register(CfgOnceAfterSucc, 32'd1);
    send_random_items(120);
  endtask

  task automatic test_steady_stream();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(CfgOnceAfterSucc, 32'd0);
    write_register(CfgTriggerModes, $urandom_range(0, 255));
    send_random_items(150);
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_sequence();
    test_polarity_and_modes();
    test_debounce_extremes();
    test_cooldown_extremes();
    test_latch_blocking();
    test_steady_stream();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Covered %0d input transfers and %0d checked results over %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Start requests issued: %0d; field mismatches: %0d.", requests_seen,
             mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/detg_pkg.sv
rtl/debounced_edge_trigger_gate_top.sv
rtl/detg_checker.sv
dv/tb_debounced_edge_trigger_gate_top.sv
